// ===== design/spds_pkg.sv =====
// ----------------------------------------------------------------------------
// spds_pkg
// Types, codes and reset constants shared by the power-down sequencer files.
// ----------------------------------------------------------------------------
`default_nettype none

package spds_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned SEQ_W   = 3;
  localparam int unsigned PHASE_W = 2;
  localparam int unsigned CFG_IDX_W = 3;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK10MS     = 3'd0,
    CMD_START        = 3'd1,
    CMD_START_LEAST  = 3'd2,
    CMD_CONTINUE     = 3'd3,
    CMD_TICK1S       = 3'd4,
    CMD_NO_SLEEP     = 3'd5
  } cmd_t;

  // sequence state, one-hot inside the block
  typedef enum logic [4:0] {
    SEQ_IDLE = 5'b00001,
    SEQ_RUN  = 5'b00010,
    SEQ_EXIT = 5'b00100,
    SEQ_PREP = 5'b01000,
    SEQ_GOTO = 5'b10000
  } seq_t;

  // sequence state codes on the result beat
  localparam logic [SEQ_W-1:0] SEQ_CODE_IDLE = 3'd0;
  localparam logic [SEQ_W-1:0] SEQ_CODE_RUN  = 3'd1;
  localparam logic [SEQ_W-1:0] SEQ_CODE_EXIT = 3'd2;
  localparam logic [SEQ_W-1:0] SEQ_CODE_PREP = 3'd3;
  localparam logic [SEQ_W-1:0] SEQ_CODE_GOTO = 3'd4;

  // system phase codes
  localparam logic [PHASE_W-1:0] PH_INIT = 2'd0;
  localparam logic [PHASE_W-1:0] PH_RUN  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_PREP = 2'd2;
  localparam logic [PHASE_W-1:0] PH_WAIT = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_TIME  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_TIME = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREP_TIME = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_SEC  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_SLEEP  = 3'd4;

  // reset values
  localparam logic [TIME_W-1:0] RUN_TIME_RST  = 16'd1;
  localparam logic [TIME_W-1:0] EXIT_TIME_RST = 16'd0;
  localparam logic [TIME_W-1:0] PREP_TIME_RST = 16'd0;
  localparam logic [TIME_W-1:0] WAKE_SEC_RST  = 16'd15;
  localparam logic [TIME_W-1:0] NO_SLEEP_RST  = 16'd10;

  typedef struct packed {
    logic [TIME_W-1:0] run_time_reload;
    logic [TIME_W-1:0] exit_time_reload;
    logic [TIME_W-1:0] prepare_time_reload;
    logic [TIME_W-1:0] wake_seconds;
    logic [TIME_W-1:0] no_sleep_reload;
  } cfg_t;

  typedef struct packed {
    seq_t               seq;
    logic [PHASE_W-1:0] phase;
    logic [TIME_W-1:0]  run_timer;
    logic [TIME_W-1:0]  exit_timer;
    logic [TIME_W-1:0]  prep_timer;
    logic [TIME_W-1:0]  no_sleep;
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] run_time;
    logic              wake_pin;
    logic              prepare_ready;
    logic              goto_ready;
    logic              continue_ready;
  } item_t;

  typedef struct packed {
    logic [SEQ_W-1:0]   seq_state;
    logic [PHASE_W-1:0] sys_phase;
    logic               exit_request;
    logic               exit_granted;
    logic               prepare_request;
    logic               goto_request;
    logic               enter_standby;
    logic [TIME_W-1:0]  standby_wake_seconds;
  } res_t;

  function automatic logic [SEQ_W-1:0] seq_code(input seq_t s);
    logic [SEQ_W-1:0] c;
    unique case (s)
      SEQ_IDLE: c = SEQ_CODE_IDLE;
      SEQ_RUN:  c = SEQ_CODE_RUN;
      SEQ_EXIT: c = SEQ_CODE_EXIT;
      SEQ_PREP: c = SEQ_CODE_PREP;
      SEQ_GOTO: c = SEQ_CODE_GOTO;
      default:  c = SEQ_CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/spds_if.sv =====
// ----------------------------------------------------------------------------
// spds_in_if / spds_out_if
// Valid/ready channels carrying command beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface spds_in_if;
  logic                           valid;
  logic                           ready;
  logic [spds_pkg::CMD_W-1:0]     cmd;
  logic [spds_pkg::TIME_W-1:0]    run_time;
  logic                           wake_pin;
  logic                           prepare_ready;
  logic                           goto_ready;
  logic                           continue_ready;

  modport source (
    output valid, cmd, run_time, wake_pin, prepare_ready, goto_ready, continue_ready,
    input  ready
  );
  modport sink (
    input  valid, cmd, run_time, wake_pin, prepare_ready, goto_ready, continue_ready,
    output ready
  );
endinterface

interface spds_out_if;
  logic                           valid;
  logic                           ready;
  logic [spds_pkg::SEQ_W-1:0]     seq_state;
  logic [spds_pkg::PHASE_W-1:0]   sys_phase;
  logic                           exit_request;
  logic                           exit_granted;
  logic                           prepare_request;
  logic                           goto_request;
  logic                           enter_standby;
  logic [spds_pkg::TIME_W-1:0]    standby_wake_seconds;

  modport source (
    output valid, seq_state, sys_phase, exit_request, exit_granted, prepare_request,
           goto_request, enter_standby, standby_wake_seconds,
    input  ready
  );
  modport sink (
    input  valid, seq_state, sys_phase, exit_request, exit_granted, prepare_request,
           goto_request, enter_standby, standby_wake_seconds,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/spds_step.sv =====
// ----------------------------------------------------------------------------
// spds_step
// Next-state and result logic for one command beat.
// ----------------------------------------------------------------------------
`default_nettype none

module spds_step (
  input  spds_pkg::state_t cur,
  input  spds_pkg::cfg_t   cfg,
  input  spds_pkg::item_t  item,
  output spds_pkg::state_t nxt,
  output spds_pkg::res_t   res
);

  logic exit_req;
  logic exit_ok;
  logic prep_req;
  logic goto_req;
  logic standby;
  logic go_goto;
  logic may_start;

  assign may_start = (cur.seq == spds_pkg::SEQ_IDLE) || (cur.seq == spds_pkg::SEQ_RUN) ||
                     (cur.seq == spds_pkg::SEQ_EXIT);

  always_comb begin
    nxt      = cur;
    exit_req = 1'b0;
    exit_ok  = 1'b0;
    prep_req = 1'b0;
    goto_req = 1'b0;
    standby  = 1'b0;
    go_goto  = 1'b0;
    unique case (spds_pkg::cmd_t'(item.cmd))
      spds_pkg::CMD_TICK10MS: begin
        unique case (cur.seq)
          spds_pkg::SEQ_RUN: begin
            nxt.phase = spds_pkg::PH_RUN;
            if (cur.run_timer != '0) begin
              nxt.run_timer = cur.run_timer - 1'b1;
            end else begin
              exit_req = 1'b1;
              if (item.wake_pin && (cur.no_sleep < cfg.no_sleep_reload)) begin
                nxt.no_sleep = cfg.no_sleep_reload;
              end
              exit_ok = !item.wake_pin && (cur.no_sleep == '0);
              if (exit_ok) begin
                nxt.seq        = spds_pkg::SEQ_EXIT;
                nxt.exit_timer = cfg.exit_time_reload;
              end
            end
          end
          spds_pkg::SEQ_EXIT: begin
            if (cur.exit_timer != '0) begin
              nxt.exit_timer = cur.exit_timer - 1'b1;
            end else begin
              nxt.phase = spds_pkg::PH_PREP;
              prep_req  = 1'b1;
              if (item.prepare_ready) begin
                nxt.seq        = spds_pkg::SEQ_PREP;
                nxt.prep_timer = cfg.prepare_time_reload;
              end
            end
          end
          spds_pkg::SEQ_PREP: begin
            if (cur.prep_timer != '0) begin
              nxt.prep_timer = cur.prep_timer - 1'b1;
            end else begin
              nxt.phase = spds_pkg::PH_WAIT;
              goto_req  = 1'b1;
              if (item.goto_ready) begin
                nxt.seq = spds_pkg::SEQ_GOTO;
                go_goto = 1'b1;
              end
            end
          end
          spds_pkg::SEQ_GOTO: begin
            go_goto = 1'b1;
          end
          default: begin
          end
        endcase
        if (go_goto) begin
          standby = 1'b1;
          if (item.continue_ready) begin
            nxt.seq       = spds_pkg::SEQ_RUN;
            nxt.run_timer = cfg.run_time_reload;
          end
        end
      end
      spds_pkg::CMD_START: begin
        if (may_start) begin
          nxt.seq       = spds_pkg::SEQ_RUN;
          nxt.run_timer = cfg.run_time_reload;
        end
      end
      spds_pkg::CMD_START_LEAST: begin
        if (may_start) begin
          nxt.seq = spds_pkg::SEQ_RUN;
          if (cur.run_timer < item.run_time) begin
            nxt.run_timer = item.run_time;
          end
        end
      end
      spds_pkg::CMD_CONTINUE: begin
        if (item.continue_ready) begin
          nxt.seq       = spds_pkg::SEQ_RUN;
          nxt.run_timer = cfg.run_time_reload;
        end
      end
      spds_pkg::CMD_TICK1S: begin
        if (cur.no_sleep != '0) begin
          nxt.no_sleep = cur.no_sleep - 1'b1;
        end
      end
      spds_pkg::CMD_NO_SLEEP: begin
        nxt.no_sleep = cfg.no_sleep_reload;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.seq_state            = spds_pkg::seq_code(nxt.seq);
    res.sys_phase            = nxt.phase;
    res.exit_request         = exit_req;
    res.exit_granted         = exit_ok;
    res.prepare_request      = prep_req;
    res.goto_request         = goto_req;
    res.enter_standby        = standby;
    res.standby_wake_seconds = standby ? cfg.wake_seconds : '0;
  end

endmodule

`default_nettype wire

// ===== design/staged_power_down_sequencer.sv =====
// ----------------------------------------------------------------------------
// staged_power_down_sequencer
// Staged power-down sequencer: run, exit-run, prepare and goto stages on
// 10 ms ticks, with wake-pin and no-sleep hold checks before exit.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  in_if     in   valid / ready    cmd, run_time, wake_pin, grants
//  out_if    out  valid / ready    state, phase, request flags, standby
//  cfg_*     in   cfg_we           cfg_index, cfg_data (16 bit)
//
//  one command beat per cycle; its result beat is valid the next cycle
//  the single result register decides the rate: a new beat is taken when it
//  is empty or being drained in the same cycle
//  synchronous active-low reset loads the reset register values, idle state
// ----------------------------------------------------------------------------
`default_nettype none

module staged_power_down_sequencer (
  input  wire                             clk,
  input  wire                             rst_n,
  spds_in_if.sink                         in_if,
  spds_out_if.source                      out_if,
  input  wire                             cfg_we,
  input  wire [spds_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [spds_pkg::TIME_W-1:0]      cfg_data
);

  spds_pkg::cfg_t   cfg_r;
  spds_pkg::state_t st_r;
  spds_pkg::state_t st_nxt;
  spds_pkg::item_t  item;
  spds_pkg::res_t   res_nxt;
  spds_pkg::res_t   res_r;
  logic             out_valid_r;
  logic             in_acc;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_acc      = in_if.valid && in_if.ready;

  assign item.cmd            = in_if.cmd;
  assign item.run_time       = in_if.run_time;
  assign item.wake_pin       = in_if.wake_pin;
  assign item.prepare_ready  = in_if.prepare_ready;
  assign item.goto_ready     = in_if.goto_ready;
  assign item.continue_ready = in_if.continue_ready;

  spds_step u_step (
    .cur  (st_r),
    .cfg  (cfg_r),
    .item (item),
    .nxt  (st_nxt),
    .res  (res_nxt)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.run_time_reload     <= spds_pkg::RUN_TIME_RST;
      cfg_r.exit_time_reload    <= spds_pkg::EXIT_TIME_RST;
      cfg_r.prepare_time_reload <= spds_pkg::PREP_TIME_RST;
      cfg_r.wake_seconds        <= spds_pkg::WAKE_SEC_RST;
      cfg_r.no_sleep_reload     <= spds_pkg::NO_SLEEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spds_pkg::CFG_RUN_TIME:  cfg_r.run_time_reload     <= cfg_data;
        spds_pkg::CFG_EXIT_TIME: cfg_r.exit_time_reload    <= cfg_data;
        spds_pkg::CFG_PREP_TIME: cfg_r.prepare_time_reload <= cfg_data;
        spds_pkg::CFG_WAKE_SEC:  cfg_r.wake_seconds        <= cfg_data;
        spds_pkg::CFG_NO_SLEEP:  cfg_r.no_sleep_reload     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.seq        <= spds_pkg::SEQ_IDLE;
      st_r.phase      <= spds_pkg::PH_INIT;
      st_r.run_timer  <= spds_pkg::RUN_TIME_RST;
      st_r.exit_timer <= spds_pkg::EXIT_TIME_RST;
      st_r.prep_timer <= spds_pkg::PREP_TIME_RST;
      st_r.no_sleep   <= '0;
    end else if (in_acc) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_if.valid                = out_valid_r;
  assign out_if.seq_state            = res_r.seq_state;
  assign out_if.sys_phase            = res_r.sys_phase;
  assign out_if.exit_request         = res_r.exit_request;
  assign out_if.exit_granted         = res_r.exit_granted;
  assign out_if.prepare_request      = res_r.prepare_request;
  assign out_if.goto_request         = res_r.goto_request;
  assign out_if.enter_standby        = res_r.enter_standby;
  assign out_if.standby_wake_seconds = res_r.standby_wake_seconds;

`ifndef SYNTH
  a_acc_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted beat produced no result");

  a_grant_needs_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.exit_granted |-> res_r.exit_request)
    else $error("exit grant without exit request");

  a_grant_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.exit_granted |-> res_r.seq_state == spds_pkg::SEQ_CODE_EXIT)
    else $error("exit granted but sequence not in exit-run");

  a_wake_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.enter_standby |-> res_r.standby_wake_seconds == '0)
    else $error("wake time shown without standby");

  a_state_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> res_r.seq_state == spds_pkg::seq_code(st_r.seq))
    else $error("result state differs from held state");
`endif

endmodule

`default_nettype wire

// ===== bench/staged_power_down_sequencer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// staged_power_down_sequencer_test
// Drives command beats through the power-down sequencer under random input
// gaps and output stalls, and checks every status beat field by field. The
// expected beats come from the directed rows that give them, else from a
// local model of the stage timers, grants and no-sleep hold. A short table of
// directed beats walks every command and stage, then random beats run under
// several register settings, including all zeros and all ones.
// ----------------------------------------------------------------------------

module staged_power_down_sequencer_test;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_BEATS = 230;
  localparam int unsigned HOLD_CYCLES = 150;

  localparam logic [spds_pkg::CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [spds_pkg::CMD_W-1:0] CMD_SPARE7 = 3'd7;

  typedef logic [spds_pkg::TIME_W-1:0] tick_count_t;

  typedef struct packed {
    spds_pkg::item_t beat;
    logic            typed;
    spds_pkg::res_t  want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [spds_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [spds_pkg::TIME_W-1:0] cfg_data;

  spds_in_if  in_if();
  spds_out_if out_if();

  staged_power_down_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // local copy of the sequencer state and registers
  spds_pkg::cfg_t shadow;
  logic [spds_pkg::SEQ_W-1:0] seq_now;
  logic [spds_pkg::PHASE_W-1:0] phase_now;
  logic [spds_pkg::TIME_W-1:0] run_left;
  logic [spds_pkg::TIME_W-1:0] exit_left;
  logic [spds_pkg::TIME_W-1:0] prep_left;
  logic [spds_pkg::TIME_W-1:0] hold_left;

  spds_pkg::res_t pending_status[$];
  spds_pkg::res_t seen;
  int unsigned status_count = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;

  function automatic spds_pkg::res_t advance_sequencer(spds_pkg::item_t b);
    spds_pkg::res_t r;
    bit again;
    r = '0;
    case (b.cmd)
      spds_pkg::CMD_TICK10MS: begin
        do begin
          again = 1'b0;
          case (seq_now)
            spds_pkg::SEQ_CODE_RUN: begin
              phase_now = spds_pkg::PH_RUN;
              if (run_left != 0) begin
                run_left = run_left - 1'b1;
              end else begin
                r.exit_request = 1'b1;
                if (b.wake_pin && hold_left < shadow.no_sleep_reload)
                  hold_left = shadow.no_sleep_reload;
                r.exit_granted = !b.wake_pin && hold_left == 0;
                if (r.exit_granted) begin
                  seq_now = spds_pkg::SEQ_CODE_EXIT;
                  exit_left = shadow.exit_time_reload;
                end
              end
            end
            spds_pkg::SEQ_CODE_EXIT: begin
              if (exit_left != 0) begin
                exit_left = exit_left - 1'b1;
              end else begin
                phase_now = spds_pkg::PH_PREP;
                r.prepare_request = 1'b1;
                if (b.prepare_ready) begin
                  seq_now = spds_pkg::SEQ_CODE_PREP;
                  prep_left = shadow.prepare_time_reload;
                end
              end
            end
            spds_pkg::SEQ_CODE_PREP: begin
              if (prep_left != 0) begin
                prep_left = prep_left - 1'b1;
              end else begin
                phase_now = spds_pkg::PH_WAIT;
                r.goto_request = 1'b1;
                if (b.goto_ready) begin
                  seq_now = spds_pkg::SEQ_CODE_GOTO;
                  again = 1'b1;
                end
              end
            end
            spds_pkg::SEQ_CODE_GOTO: begin
              r.enter_standby = 1'b1;
              if (b.continue_ready) begin
                seq_now = spds_pkg::SEQ_CODE_RUN;
                run_left = shadow.run_time_reload;
              end
            end
            default: ;
          endcase
        end while (again);
      end
      spds_pkg::CMD_START: begin
        if (seq_now == spds_pkg::SEQ_CODE_IDLE || seq_now == spds_pkg::SEQ_CODE_RUN ||
            seq_now == spds_pkg::SEQ_CODE_EXIT) begin
          run_left = shadow.run_time_reload;
          seq_now = spds_pkg::SEQ_CODE_RUN;
        end
      end
      spds_pkg::CMD_START_LEAST: begin
        if (seq_now == spds_pkg::SEQ_CODE_IDLE || seq_now == spds_pkg::SEQ_CODE_RUN ||
            seq_now == spds_pkg::SEQ_CODE_EXIT) begin
          if (run_left < b.run_time)
            run_left = b.run_time;
          seq_now = spds_pkg::SEQ_CODE_RUN;
        end
      end
      spds_pkg::CMD_CONTINUE: begin
        if (b.continue_ready) begin
          seq_now = spds_pkg::SEQ_CODE_RUN;
          run_left = shadow.run_time_reload;
        end
      end
      spds_pkg::CMD_TICK1S: begin
        if (hold_left != 0)
          hold_left = hold_left - 1'b1;
      end
      spds_pkg::CMD_NO_SLEEP: hold_left = shadow.no_sleep_reload;
      default: ;
    endcase
    r.seq_state = seq_now;
    r.sys_phase = phase_now;
    r.standby_wake_seconds = r.enter_standby ? shadow.wake_seconds : '0;
    return r;
  endfunction

  function automatic spds_pkg::item_t beat(logic [spds_pkg::CMD_W-1:0] c,
                                           logic [spds_pkg::TIME_W-1:0] rt, logic wk,
                                           logic pr, logic gr, logic cr);
    spds_pkg::item_t b;
    b.cmd = c;
    b.run_time = rt;
    b.wake_pin = wk;
    b.prepare_ready = pr;
    b.goto_ready = gr;
    b.continue_ready = cr;
    return b;
  endfunction

  // status under the reset register values
  function automatic spds_pkg::res_t status(logic [spds_pkg::SEQ_W-1:0] s,
                                            logic [spds_pkg::PHASE_W-1:0] ph, logic er,
                                            logic eg, logic prq, logic grq, logic sb);
    spds_pkg::res_t r;
    r.seq_state = s;
    r.sys_phase = ph;
    r.exit_request = er;
    r.exit_granted = eg;
    r.prepare_request = prq;
    r.goto_request = grq;
    r.enter_standby = sb;
    r.standby_wake_seconds = sb ? spds_pkg::WAKE_SEC_RST : '0;
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned pick;
    if (no_gaps)
      return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      return 0;
    if (pick < 95)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_status(spds_pkg::res_t got, spds_pkg::res_t want);
    if (got.seq_state !== want.seq_state)
      report_mismatch($sformatf("beat %0d seq_state got %0d expected %0d",
                                status_count, got.seq_state, want.seq_state));
    if (got.sys_phase !== want.sys_phase)
      report_mismatch($sformatf("beat %0d sys_phase got %0d expected %0d",
                                status_count, got.sys_phase, want.sys_phase));
    if (got.exit_request !== want.exit_request)
      report_mismatch($sformatf("beat %0d exit_request got %0b expected %0b",
                                status_count, got.exit_request, want.exit_request));
    if (got.exit_granted !== want.exit_granted)
      report_mismatch($sformatf("beat %0d exit_granted got %0b expected %0b",
                                status_count, got.exit_granted, want.exit_granted));
    if (got.prepare_request !== want.prepare_request)
      report_mismatch($sformatf("beat %0d prepare_request got %0b expected %0b",
                                status_count, got.prepare_request, want.prepare_request));
    if (got.goto_request !== want.goto_request)
      report_mismatch($sformatf("beat %0d goto_request got %0b expected %0b",
                                status_count, got.goto_request, want.goto_request));
    if (got.enter_standby !== want.enter_standby)
      report_mismatch($sformatf("beat %0d enter_standby got %0b expected %0b",
                                status_count, got.enter_standby, want.enter_standby));
    if (got.standby_wake_seconds !== want.standby_wake_seconds)
      report_mismatch($sformatf("beat %0d standby_wake_seconds got %0d expected %0d",
                                status_count, got.standby_wake_seconds,
                                want.standby_wake_seconds));
  endtask

  task automatic send_beat(spds_pkg::item_t b, logic typed, spds_pkg::res_t want);
    spds_pkg::res_t predicted;
    in_if.valid <= 1'b1;
    in_if.cmd <= b.cmd;
    in_if.run_time <= b.run_time;
    in_if.wake_pin <= b.wake_pin;
    in_if.prepare_ready <= b.prepare_ready;
    in_if.goto_ready <= b.goto_ready;
    in_if.continue_ready <= b.continue_ready;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    predicted = advance_sequencer(b);
    pending_status.push_back(typed ? want : predicted);
  endtask

  task automatic idle_gap();
    int unsigned n;
    n = gap_len();
    if (n != 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic put_reg(logic [spds_pkg::CFG_IDX_W-1:0] idx,
                         logic [spds_pkg::TIME_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      spds_pkg::CFG_RUN_TIME:  shadow.run_time_reload = val;
      spds_pkg::CFG_EXIT_TIME: shadow.exit_time_reload = val;
      spds_pkg::CFG_PREP_TIME: shadow.prepare_time_reload = val;
      spds_pkg::CFG_WAKE_SEC:  shadow.wake_seconds = val;
      spds_pkg::CFG_NO_SLEEP:  shadow.no_sleep_reload = val;
      default: ;
    endcase
  endtask

  task automatic write_config(spds_pkg::cfg_t c);
    put_reg(spds_pkg::CFG_RUN_TIME, c.run_time_reload);
    put_reg(spds_pkg::CFG_EXIT_TIME, c.exit_time_reload);
    put_reg(spds_pkg::CFG_PREP_TIME, c.prepare_time_reload);
    put_reg(spds_pkg::CFG_WAKE_SEC, c.wake_seconds);
    put_reg(spds_pkg::CFG_NO_SLEEP, c.no_sleep_reload);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("staged_power_down_sequencer_test: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      seen = {out_if.seq_state, out_if.sys_phase, out_if.exit_request, out_if.exit_granted,
              out_if.prepare_request, out_if.goto_request, out_if.enter_standby,
              out_if.standby_wake_seconds};
      if (pending_status.size() == 0)
        report_mismatch($sformatf("status beat %0d with nothing expected", status_count));
      else
        check_status(seen, pending_status.pop_front());
      status_count++;
    end
  end

  initial begin : receiver
    int unsigned stall;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = gap_len();
      end
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    row_t directed[$];
    spds_pkg::item_t b;
    spds_pkg::cfg_t setting;
    int unsigned pick;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.cmd = '0;
    in_if.run_time = '0;
    in_if.wake_pin = 1'b0;
    in_if.prepare_ready = 1'b0;
    in_if.goto_ready = 1'b0;
    in_if.continue_ready = 1'b0;

    shadow = {spds_pkg::RUN_TIME_RST, spds_pkg::EXIT_TIME_RST, spds_pkg::PREP_TIME_RST,
              spds_pkg::WAKE_SEC_RST, spds_pkg::NO_SLEEP_RST};
    seq_now = spds_pkg::SEQ_CODE_IDLE;
    phase_now = spds_pkg::PH_INIT;
    run_left = spds_pkg::RUN_TIME_RST;
    exit_left = spds_pkg::EXIT_TIME_RST;
    prep_left = spds_pkg::PREP_TIME_RST;
    hold_left = '0;

    // idle, spare codes, refused continue
    directed.push_back({beat(spds_pkg::CMD_TICK10MS, 16'h0000, 0, 1, 1, 1), 1'b1,
                        status(spds_pkg::SEQ_CODE_IDLE, spds_pkg::PH_INIT, 0, 0, 0, 0, 0)});
    directed.push_back({beat(CMD_SPARE6, 16'hFFFF, 1, 1, 1, 1), 1'b1,
                        status(spds_pkg::SEQ_CODE_IDLE, spds_pkg::PH_INIT, 0, 0, 0, 0, 0)});
    directed.push_back({beat(CMD_SPARE7, 16'h0000, 0, 0, 0, 0), 1'b1,
                        status(spds_pkg::SEQ_CODE_IDLE, spds_pkg::PH_INIT, 0, 0, 0, 0, 0)});
    directed.push_back({beat(spds_pkg::CMD_TICK1S, 16'h0000, 0, 0, 0, 0), 1'b1,
                        status(spds_pkg::SEQ_CODE_IDLE, spds_pkg::PH_INIT, 0, 0, 0, 0, 0)});
    directed.push_back({beat(spds_pkg::CMD_CONTINUE, 16'h0000, 0, 0, 0, 0), 1'b1,
                        status(spds_pkg::SEQ_CODE_IDLE, spds_pkg::PH_INIT, 0, 0, 0, 0, 0)});
    // full pass through every stage
    directed.push_back({beat(spds_pkg::CMD_START_LEAST, 16'hFFFF, 0, 0, 0, 0), 1'b1,
                        status(spds_pkg::SEQ_CODE_RUN, spds_pkg::PH_INIT, 0, 0, 0, 0, 0)});
    directed.push_back({beat(spds_pkg::CMD_START, 16'h0000, 0, 0, 0, 0), 1'b1,
                        status(spds_pkg::SEQ_CODE_RUN, spds_pkg::PH_INIT, 0, 0, 0, 0, 0)});
    directed.push_back({beat(spds_pkg::CMD_TICK10MS, 16'h0000, 0, 0, 0, 0), 1'b1,
                        status(spds_pkg::SEQ_CODE_RUN, spds_pkg::PH_RUN, 0, 0, 0, 0, 0)});
    directed.push_back({beat(spds_pkg::CMD_TICK10MS, 16'h0000, 0, 0, 0, 0), 1'b1,
                        status(spds_pkg::SEQ_CODE_EXIT, spds_pkg::PH_RUN, 1, 1, 0, 0, 0)});
    directed.push_back({beat(spds_pkg::CMD_TICK10MS, 16'h0000, 0, 0, 0, 0), 1'b1,
                        status(spds_pkg::SEQ_CODE_EXIT, spds_pkg::PH_PREP, 0, 0, 1, 0, 0)});
    directed.push_back({beat(spds_pkg::CMD_TICK10MS, 16'h0000, 0, 1, 0, 0), 1'b1,
                        status(spds_pkg::SEQ_CODE_PREP, spds_pkg::PH_PREP, 0, 0, 1, 0, 0)});
    directed.push_back({beat(spds_pkg::CMD_START, 16'h0000, 0, 0, 0, 0), 1'b1,
                        status(spds_pkg::SEQ_CODE_PREP, spds_pkg::PH_PREP, 0, 0, 0, 0, 0)});
    directed.push_back({beat(spds_pkg::CMD_START_LEAST, 16'h0000, 0, 0, 0, 0), 1'b1,
                        status(spds_pkg::SEQ_CODE_PREP, spds_pkg::PH_PREP, 0, 0, 0, 0, 0)});
    directed.push_back({beat(spds_pkg::CMD_TICK10MS, 16'h0000, 0, 0, 0, 0), 1'b1,
                        status(spds_pkg::SEQ_CODE_PREP, spds_pkg::PH_WAIT, 0, 0, 0, 1, 0)});
    directed.push_back({beat(spds_pkg::CMD_TICK10MS, 16'h0000, 0, 0, 1, 0), 1'b1,
                        status(spds_pkg::SEQ_CODE_GOTO, spds_pkg::PH_WAIT, 0, 0, 0, 1, 1)});
    directed.push_back({beat(spds_pkg::CMD_START, 16'h0000, 0, 0, 0, 0), 1'b1,
                        status(spds_pkg::SEQ_CODE_GOTO, spds_pkg::PH_WAIT, 0, 0, 0, 0, 0)});
    directed.push_back({beat(spds_pkg::CMD_TICK10MS, 16'h0000, 0, 0, 0, 0), 1'b1,
                        status(spds_pkg::SEQ_CODE_GOTO, spds_pkg::PH_WAIT, 0, 0, 0, 0, 1)});
    directed.push_back({beat(spds_pkg::CMD_TICK10MS, 16'h0000, 0, 0, 0, 1), 1'b1,
                        status(spds_pkg::SEQ_CODE_RUN, spds_pkg::PH_WAIT, 0, 0, 0, 0, 1)});
    // wake pin and no-sleep hold
    directed.push_back({beat(spds_pkg::CMD_TICK10MS, 16'h0000, 0, 0, 0, 0), 1'b1,
                        status(spds_pkg::SEQ_CODE_RUN, spds_pkg::PH_RUN, 0, 0, 0, 0, 0)});
    directed.push_back({beat(spds_pkg::CMD_TICK10MS, 16'h0000, 1, 0, 0, 0), 1'b1,
                        status(spds_pkg::SEQ_CODE_RUN, spds_pkg::PH_RUN, 1, 0, 0, 0, 0)});
    directed.push_back({beat(spds_pkg::CMD_TICK10MS, 16'h0000, 1, 0, 0, 0), 1'b1,
                        status(spds_pkg::SEQ_CODE_RUN, spds_pkg::PH_RUN, 1, 0, 0, 0, 0)});
    directed.push_back({beat(spds_pkg::CMD_TICK10MS, 16'h0000, 0, 0, 0, 0), 1'b1,
                        status(spds_pkg::SEQ_CODE_RUN, spds_pkg::PH_RUN, 1, 0, 0, 0, 0)});
    directed.push_back({beat(spds_pkg::CMD_TICK1S, 16'h0000, 0, 0, 0, 0), 1'b0,
                        spds_pkg::res_t'('0)});
    directed.push_back({beat(spds_pkg::CMD_NO_SLEEP, 16'h0000, 0, 0, 0, 0), 1'b0,
                        spds_pkg::res_t'('0)});
    directed.push_back({beat(spds_pkg::CMD_CONTINUE, 16'h0000, 0, 0, 0, 1), 1'b0,
                        spds_pkg::res_t'('0)});
    directed.push_back({beat(spds_pkg::CMD_START_LEAST, 16'h0005, 0, 0, 0, 0), 1'b0,
                        spds_pkg::res_t'('0)});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      send_beat(directed[i].beat, directed[i].typed, directed[i].want);
      idle_gap();
    end

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        setting = '0;
      end else if (p == 1) begin
        setting = '1;
      end else begin
        setting.run_time_reload = tick_count_t'($urandom_range(0, 4));
        setting.exit_time_reload = tick_count_t'($urandom_range(0, 3));
        setting.prepare_time_reload = tick_count_t'($urandom_range(0, 3));
        setting.wake_seconds = tick_count_t'($urandom);
        setting.no_sleep_reload = ($urandom_range(0, 7) == 0) ? tick_count_t'($urandom) :
                                  tick_count_t'($urandom_range(0, 4));
      end
      drain();
      write_config(setting);
      no_gaps = (p == 2) || (p == 3);
      if (p == 2)
        hold_req = 1'b1;
      for (int k = 0; k < PHASE_BEATS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55)
          b.cmd = spds_pkg::CMD_TICK10MS;
        else if (pick < 63)
          b.cmd = spds_pkg::CMD_START;
        else if (pick < 70)
          b.cmd = spds_pkg::CMD_START_LEAST;
        else if (pick < 77)
          b.cmd = spds_pkg::CMD_CONTINUE;
        else if (pick < 89)
          b.cmd = spds_pkg::CMD_TICK1S;
        else if (pick < 94)
          b.cmd = spds_pkg::CMD_NO_SLEEP;
        else
          b.cmd = pick[0] ? CMD_SPARE7 : CMD_SPARE6;
        b.run_time = ($urandom_range(0, 3) == 0) ? tick_count_t'($urandom) :
                     tick_count_t'($urandom_range(0, 8));
        b.wake_pin = ($urandom_range(0, 4) == 0);
        b.prepare_ready = ($urandom_range(0, 3) != 0);
        b.goto_ready = ($urandom_range(0, 3) != 0);
        b.continue_ready = ($urandom_range(0, 3) != 0);
        send_beat(b, 1'b0, spds_pkg::res_t'('0));
        idle_gap();
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("staged_power_down_sequencer_test: PASS");
    else
      $display("staged_power_down_sequencer_test: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
design/spds_pkg.sv
design/spds_if.sv
design/spds_step.sv
design/staged_power_down_sequencer.sv
bench/staged_power_down_sequencer_test.sv
